// File: sv/aot_pkg.sv
// Shared types, constants and tables for the arc odometry tracker.
// No dependencies; imported by every module of the block.
`default_nettype none
package aot_pkg;

	localparam int POS_WIDTH_DEF  = 48;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int CORDIC_STEPS   = 30;
	localparam int MUL_W          = 33;
	localparam int DEN_W          = 33;

	localparam logic [30:0] GYRO_SCALE_RST = 31'd23592960;
	localparam logic [32:0] PI_Q30         = 33'd3373259426;
	localparam logic [32:0] INV2PI_Q32     = 33'd683565276;
	// ceil(2^37 / 45): exact quotient by 45 for dividends below 2^31
	localparam logic [32:0] RCP_45         = 33'd3054198967;
	localparam logic signed [33:0] CORDIC_K_Q30 = 34'sd652032874;

	typedef enum logic [1:0] {
		REG_GYRO_SCALE  = 2'd0,
		REG_SIDE_OFFSET = 2'd1,
		REG_FWD_OFFSET  = 2'd2,
		REG_UNUSED      = 2'd3
	} aot_reg_t;

	typedef enum logic [4:0] {
		S_IDLE, S_MAG, S_HDIV_GO, S_HDIV_WAIT, S_RMUL, S_RRCP, S_RQUO,
		S_DELTA, S_PH1, S_CORD1_GO, S_CORD1_WAIT, S_CDIV_GO, S_CDIV_WAIT,
		S_M1, S_M2, S_M3, S_M4, S_M5, S_PH2, S_CORD2_GO, S_CORD2_WAIT,
		S_ROT_MUL, S_ROT_ACC, S_DONE
	} aot_state_t;

	function automatic logic [31:0] atan_turn(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0:  v = 32'h20000000;
			5'd1:  v = 32'h12E4051E;
			5'd2:  v = 32'h09FB385B;
			5'd3:  v = 32'h051111D4;
			5'd4:  v = 32'h028B0D43;
			5'd5:  v = 32'h0145D7E1;
			5'd6:  v = 32'h00A2F61E;
			5'd7:  v = 32'h00517C55;
			5'd8:  v = 32'h0028BE53;
			5'd9:  v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			5'd24: v = 32'h00000029;
			5'd25: v = 32'h00000014;
			5'd26: v = 32'h0000000A;
			5'd27: v = 32'h00000005;
			5'd28: v = 32'h00000003;
			5'd29: v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

// File: sv/aot_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on aot_pkg for the divisor width.
`default_nettype none
module aot_div import aot_pkg::*; #(
	parameter int DW = 57
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DW-1:0]    num,
	input  wire logic [DEN_W-1:0] den,
	output logic                  done,
	output logic [DW-1:0]         quo
);
	localparam int CW = $clog2(DW + 1);

	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [DW-1:0]    sh_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DEN_W:0]   shifted;
	logic [DEN_W+1:0] trial;
	logic             qbit;

	assign shifted = {rem_q, sh_q[DW-1]};
	assign trial   = {1'b0, shifted} - {2'b00, den_q};
	assign qbit    = ~trial[DEN_W+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= qbit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
			sh_q  <= {sh_q[DW-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quo  = sh_q;
endmodule
`default_nettype wire

// File: sv/aot_cordic.sv
// Rotation-mode CORDIC, one step per cycle, giving sine and cosine in Q30.
// Depends on aot_pkg for the arctangent table and gain constant.
`default_nettype none
module aot_cordic import aot_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] phase,
	output logic             done,
	output logic signed [31:0] sin_o,
	output logic signed [31:0] cos_o
);
	localparam int IW = $clog2(CORDIC_STEPS);
	localparam logic signed [33:0] ONE = 34'sd1 <<< 30;

	logic signed [33:0] x_q, y_q, nx, ny;
	logic signed [32:0] z_q, nz, at;
	logic [IW-1:0]      i_q;
	logic [1:0]         quad_q;
	logic               busy_q, done_q;
	logic signed [31:0] sin_q, cos_q, cx, cy, s_n, c_n;

	function automatic logic signed [31:0] clamp30(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > ONE)
			r = 32'sd1 <<< 30;
		else if (v < -ONE)
			r = -(32'sd1 <<< 30);
		else
			r = 32'(v);
		return r;
	endfunction

	always_comb begin
		at = $signed({1'b0, atan_turn(5'(i_q))});
		if (!z_q[32]) begin
			nx = x_q - (y_q >>> i_q);
			ny = y_q + (x_q >>> i_q);
			nz = z_q - at;
		end else begin
			nx = x_q + (y_q >>> i_q);
			ny = y_q - (x_q >>> i_q);
			nz = z_q + at;
		end
		cx = clamp30(nx);
		cy = clamp30(ny);
		case (quad_q)
			2'd0: begin c_n = cx;  s_n = cy;  end
			2'd1: begin c_n = -cy; s_n = cx;  end
			2'd2: begin c_n = -cx; s_n = -cy; end
			default: begin c_n = cy; s_n = -cx; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (busy_q) begin
			i_q <= i_q + IW'(1);
			if (i_q == IW'(CORDIC_STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= CORDIC_K_Q30;
			y_q    <= '0;
			z_q    <= $signed({3'b000, phase[29:0]});
			quad_q <= phase[31:30];
		end else if (busy_q) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
			if (i_q == IW'(CORDIC_STEPS - 1)) begin
				sin_q <= s_n;
				cos_q <= c_n;
			end
		end
	end

	assign done  = done_q;
	assign sin_o = sin_q;
	assign cos_o = cos_q;
endmodule
`default_nettype wire

// File: sv/aot_mul.sv
// Shared signed multiplier with a registered product.
// Depends on aot_pkg for the operand width.
`default_nettype none
module aot_mul import aot_pkg::*; (
	input  wire logic                    clk,
	input  wire logic signed [MUL_W-1:0] a,
	input  wire logic signed [MUL_W-1:0] b,
	output logic signed [2*MUL_W-1:0]    p
);
	logic signed [2*MUL_W-1:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= a * b;
	end

	assign p = p_q;
endmodule
`default_nettype wire

// File: sv/arc_odometry_tracker_core.sv
// Arc odometry tracker top level: sequencer, state and configuration.
// Depends on aot_pkg, aot_div, aot_cordic and aot_mul.
//
// Each item takes two tracking-wheel counts and two gyro angles and yields one
// result: the saturating global position and the scaled heading. The block
// works on one item at a time and is not ready meanwhile. An item with a heading
// change makes two passes through the bit-serial divider (heading scaling, chord
// ratio), a reciprocal multiply for the degree to radian conversion, two 30-step
// CORDIC runs and the rotation products on the shared multiplier. An item with no
// heading change skips the chord divide, the chord products and one CORDIC run.
// A finished result waits in the output register while the next item is taken;
// while that register is still full the block holds its next result.
// Configuration writes are always ready; index 3 is ignored.
`default_nettype none
module arc_odometry_tracker_core import aot_pkg::*; #(
	parameter int POS_WIDTH = POS_WIDTH_DEF,
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [31:0]                 cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic signed [31:0]          side_count,
	input  wire logic signed [31:0]          forward_count,
	input  wire logic signed [31:0]          gyro_a_angle,
	input  wire logic signed [31:0]          gyro_b_angle,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic signed [POS_WIDTH-1:0]      pos_x,
	output logic signed [POS_WIDTH-1:0]      pos_y,
	output logic signed [31:0]               heading_angle
);
	localparam int DW = 41 + FRAC_BITS;
	localparam int SW = 69;
	localparam logic signed [SW-1:0] PMAX = (SW'(1) <<< (POS_WIDTH - 1)) - SW'(1);
	localparam logic signed [SW-1:0] PMIN = -PMAX - SW'(1);

	aot_state_t state_q, state_n;

	logic [30:0]        gyro_scale_q;
	logic signed [31:0] side_off_q, fwd_off_q;
	logic signed [31:0] last_side_q, last_fwd_q, last_head_q;
	logic signed [POS_WIDTH-1:0] acc_x_q, acc_y_q;
	logic signed [POS_WIDTH-1:0] pos_x_q, pos_y_q;
	logic signed [31:0] heading_q;
	logic               out_valid_q;

	logic signed [31:0] side_q, fwd_q, head_q, rad_q;
	logic signed [32:0] sum_q, ds_q, df_q, dth_q, chord_q;
	logic [40:0]        mag_q;
	logic               neg_q;
	logic signed [31:0] ratio_q;
	logic signed [63:0] lx_q, ly_q;
	logic signed [95:0] pacc_q;
	logic signed [67:0] gx_q, gy_q;
	logic [2:0]         mstep_q;

	logic               div_start, div_done;
	logic [DW-1:0]      div_num, div_quo;
	logic [DEN_W-1:0]   div_den;
	logic               cor_start, cor_done;
	logic [31:0]        cor_phase;
	logic signed [31:0] cor_sin, cor_cos;
	logic signed [MUL_W-1:0]   mul_a, mul_b;
	logic signed [2*MUL_W-1:0] mul_p;

	logic [32:0]        sum_abs, head_abs, chord_abs, dth_abs, g_den;
	logic [31:0]        h_mag, rmag, rad_mag;
	logic signed [31:0] head_n, rad_n, ratio_n;
	logic signed [32:0] ds_n, df_n, dth_n;
	logic [1:0]         term;
	logic signed [63:0] rot_src, rot_trig_src;
	logic signed [95:0] prod96, tot96;
	logic signed [67:0] term_v;
	logic signed [SW-1:0] sx, sy, nx, ny;
	logic               out_free;

	aot_div #(.DW(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(div_den),
		.done(div_done), .quo(div_quo)
	);

	aot_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cor_start), .phase(cor_phase),
		.done(cor_done), .sin_o(cor_sin), .cos_o(cor_cos)
	);

	aot_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		sum_abs   = sum_q[32] ? 33'(-sum_q) : 33'(sum_q);
		head_abs  = head_q[31] ? 33'(-33'(head_q)) : 33'(head_q);
		chord_abs = chord_q[32] ? 33'(-chord_q) : 33'(chord_q);
		dth_abs   = dth_q[32] ? 33'(-dth_q) : 33'(dth_q);
		g_den     = (gyro_scale_q == '0) ? 33'd1 : {2'b00, gyro_scale_q};
		h_mag     = (|div_quo[DW-1:31]) ? 32'h80000000 : div_quo[31:0];
		if (neg_q)
			head_n = $signed(32'd0 - h_mag);
		else
			head_n = h_mag[31] ? 32'sh7FFFFFFF : $signed(h_mag);
		rad_mag = {3'b000, mul_p[65:37]};
		rad_n   = head_q[31] ? $signed(32'd0 - rad_mag) : $signed(rad_mag);
		ds_n    = 33'(side_q) - 33'(last_side_q);
		df_n    = 33'(fwd_q) - 33'(last_fwd_q);
		dth_n   = 33'(rad_q) - 33'(last_head_q);
		rmag    = (|div_quo[DW-1:30]) ? 32'h40000000 : {2'b00, div_quo[29:0]};
		ratio_n = (chord_q[32] ^ dth_q[32]) ? $signed(32'd0 - rmag) : $signed(rmag);
		term         = mstep_q[2:1];
		rot_src      = (term == 2'd0 || term == 2'd3) ? lx_q : ly_q;
		rot_trig_src = (term == 2'd0 || term == 2'd2) ? 64'(cor_cos) : 64'(cor_sin);
		prod96 = 96'(mul_p);
		tot96  = pacc_q + (prod96 <<< 32);
		term_v = 68'(tot96 >>> 30);
		sx = SW'(acc_x_q) + SW'(gx_q);
		sy = SW'(acc_y_q) + SW'(gy_q);
		nx = (sx > PMAX) ? PMAX : ((sx < PMIN) ? PMIN : sx);
		ny = (sy > PMAX) ? PMAX : ((sy < PMIN) ? PMIN : sy);
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			S_IDLE:       if (in_valid) state_n = S_MAG;
			S_MAG:        state_n = S_HDIV_GO;
			S_HDIV_GO:    state_n = S_HDIV_WAIT;
			S_HDIV_WAIT:  if (div_done) state_n = S_RMUL;
			S_RMUL:       state_n = S_RRCP;
			S_RRCP:       state_n = S_RQUO;
			S_RQUO:       state_n = S_DELTA;
			S_DELTA:      state_n = (dth_n != '0) ? S_PH1 : S_PH2;
			S_PH1:        state_n = S_CORD1_GO;
			S_CORD1_GO:   state_n = S_CORD1_WAIT;
			S_CORD1_WAIT: if (cor_done) state_n = S_CDIV_GO;
			S_CDIV_GO:    state_n = S_CDIV_WAIT;
			S_CDIV_WAIT:  if (div_done) state_n = S_M1;
			S_M1:         state_n = S_M2;
			S_M2:         state_n = S_M3;
			S_M3:         state_n = S_M4;
			S_M4:         state_n = S_M5;
			S_M5:         state_n = S_PH2;
			S_PH2:        state_n = S_CORD2_GO;
			S_CORD2_GO:   state_n = S_CORD2_WAIT;
			S_CORD2_WAIT: if (cor_done) state_n = S_ROT_MUL;
			S_ROT_MUL:    state_n = S_ROT_ACC;
			S_ROT_ACC:    state_n = (mstep_q == 3'd7) ? S_DONE : S_ROT_MUL;
			S_DONE:       if (out_free) state_n = S_IDLE;
			default:      state_n = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		cor_start = 1'b0;
		cor_phase = '0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_HDIV_GO: begin
				div_start = 1'b1;
				div_num   = DW'(mag_q) << FRAC_BITS;
				div_den   = g_den;
			end
			S_RMUL: begin
				mul_a = $signed(head_abs);
				mul_b = $signed(PI_Q30);
			end
			S_RRCP: begin
				mul_a = $signed({2'b00, mul_p[62:32]});
				mul_b = $signed(RCP_45);
			end
			S_PH1: begin
				mul_a = dth_q;
				mul_b = $signed(INV2PI_Q32);
			end
			S_CORD1_GO: begin
				cor_start = 1'b1;
				cor_phase = mul_p[FRAC_BITS+32:FRAC_BITS+1];
			end
			S_CDIV_GO: begin
				div_start = 1'b1;
				div_num   = DW'(chord_abs) << FRAC_BITS;
				div_den   = dth_abs;
			end
			S_M1: begin
				mul_a = ds_q;
				mul_b = 33'(ratio_q);
			end
			S_M2: begin
				mul_a = chord_q;
				mul_b = 33'(side_off_q);
			end
			S_M3: begin
				mul_a = df_q;
				mul_b = 33'(ratio_q);
			end
			S_M4: begin
				mul_a = chord_q;
				mul_b = 33'(fwd_off_q);
			end
			S_PH2: begin
				mul_a = 33'(last_head_q);
				mul_b = $signed(INV2PI_Q32);
			end
			S_CORD2_GO: begin
				cor_start = 1'b1;
				cor_phase = mul_p[FRAC_BITS+31:FRAC_BITS];
			end
			S_ROT_MUL: begin
				mul_a = mstep_q[0] ? 33'($signed(rot_src[63:32]))
					: $signed({1'b0, rot_src[31:0]});
				mul_b = 33'(rot_trig_src);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			gyro_scale_q <= GYRO_SCALE_RST;
			side_off_q   <= '0;
			fwd_off_q    <= '0;
			last_side_q  <= '0;
			last_fwd_q   <= '0;
			last_head_q  <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
		end else begin
			state_q <= state_n;
			if (cfg_valid) begin
				case (cfg_index)
					REG_GYRO_SCALE:  gyro_scale_q <= cfg_data[30:0];
					REG_SIDE_OFFSET: side_off_q   <= $signed(cfg_data);
					REG_FWD_OFFSET:  fwd_off_q    <= $signed(cfg_data);
					default: begin
					end
				endcase
			end
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
				acc_x_q     <= POS_WIDTH'(nx);
				acc_y_q     <= POS_WIDTH'(ny);
				last_side_q <= side_q;
				last_fwd_q  <= fwd_q;
				last_head_q <= rad_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				side_q <= side_count;
				fwd_q  <= forward_count;
				sum_q  <= 33'(gyro_a_angle) + 33'(gyro_b_angle);
			end
			S_MAG: begin
				neg_q <= sum_q[32];
				mag_q <= (41'(sum_abs) << 7) + (41'(sum_abs) << 5) + (41'(sum_abs) << 4)
					+ (41'(sum_abs) << 2);
			end
			S_HDIV_WAIT: if (div_done) head_q <= head_n;
			S_RQUO: rad_q <= rad_n;
			S_DELTA: begin
				ds_q  <= ds_n;
				df_q  <= df_n;
				dth_q <= dth_n;
				lx_q  <= 64'(ds_n) <<< FRAC_BITS;
				ly_q  <= 64'(df_n) <<< FRAC_BITS;
			end
			S_CORD1_WAIT: if (cor_done) chord_q <= 33'(cor_sin) <<< 1;
			S_CDIV_WAIT: if (div_done) ratio_q <= ratio_n;
			S_M2: lx_q <= 64'(mul_p >>> (30 - FRAC_BITS));
			S_M3: lx_q <= lx_q + 64'(mul_p >>> 30);
			S_M4: ly_q <= 64'(mul_p >>> (30 - FRAC_BITS));
			S_M5: ly_q <= ly_q + 64'(mul_p >>> 30);
			S_CORD2_WAIT: begin
				mstep_q <= '0;
				gx_q    <= '0;
				gy_q    <= '0;
			end
			S_ROT_ACC: begin
				mstep_q <= mstep_q + 3'd1;
				if (!mstep_q[0]) begin
					pacc_q <= prod96;
				end else begin
					case (term)
						2'd0: gx_q <= gx_q + term_v;
						2'd1: gx_q <= gx_q + term_v;
						2'd2: gy_q <= gy_q + term_v;
						default: gy_q <= gy_q - term_v;
					endcase
				end
			end
			S_DONE: begin
				if (out_free) begin
					pos_x_q   <= POS_WIDTH'(nx);
					pos_y_q   <= POS_WIDTH'(ny);
					heading_q <= head_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign pos_x         = pos_x_q;
	assign pos_y         = pos_y_q;
	assign heading_angle = heading_q;

`ifndef SYNTH
	a_div_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_HDIV_WAIT || state_q == S_CDIV_WAIT))
		else $error("divider finished outside a wait state");
	a_cor_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		cor_done |-> (state_q == S_CORD1_WAIT || state_q == S_CORD2_WAIT))
		else $error("cordic finished outside a wait state");
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_DONE)
		else $error("result raised without a finished item");
`endif
endmodule
`default_nettype wire

// File: dv/arc_odometry_tracker_checker.sv
// Watching checker for the arc odometry tracker: follows the configuration, input and
// result channels, predicts each pose from its own arithmetic model and compares.
// Depends on aot_pkg for the register codes.
module arc_odometry_tracker_checker import aot_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [31:0] side_count,
	input  logic signed [31:0] forward_count,
	input  logic signed [31:0] gyro_a_angle,
	input  logic signed [31:0] gyro_b_angle,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [47:0]        pos_x,
	input  logic [47:0]        pos_y,
	input  logic [31:0]        heading_angle,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = 16;
	localparam longint Q30 = 64'sd1073741824;
	localparam longint PI_FIX = 64'sd3373259426;
	localparam longint unsigned TURN_FIX = 64'd683565276;
	localparam longint GAIN_FIX = 64'sd652032874;
	localparam longint POS_HI = 64'sd140737488355327;
	localparam longint POS_LO = -64'sd140737488355328;
	localparam longint ARC_STEP [30] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
		64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
		64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
		64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
		64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001
	};

	typedef struct {
		logic [47:0] x;
		logic [47:0] y;
		logic [31:0] h;
	} pose_t;

	pose_t  pose_q[$];
	logic [30:0] drift_div;
	longint side_off, fwd_off;
	longint prev_side, prev_fwd, prev_rad, sum_x, sum_y;

	function automatic longint clip(input longint v, input longint lo, input longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic longint mul_frac(input longint a, input longint c);
		longint hi, lo;
		hi = a >>> 30;
		lo = a - hi * Q30;
		return hi * c + ((lo * c) >>> 30);
	endfunction

	function automatic void rotate_unit(input longint ang, input int frac,
			output longint sn, output longint cs);
		longint unsigned ua, prod;
		logic [31:0] ph;
		longint x, y, z, nx;
		ua = ang;
		prod = ua * TURN_FIX;
		ph = prod >> frac;
		z = {34'd0, ph[29:0]};
		x = GAIN_FIX;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z = z - ARC_STEP[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z = z + ARC_STEP[i];
			end
			x = nx;
		end
		x = clip(x, -Q30, Q30);
		y = clip(y, -Q30, Q30);
		case (ph[31:30])
			2'd0: begin cs = x; sn = y; end
			2'd1: begin cs = -y; sn = x; end
			2'd2: begin cs = -x; sn = -y; end
			default: begin cs = y; sn = -x; end
		endcase
	endfunction

	function automatic longint scale_heading(input longint total);
		longint unsigned mag, g, ip, h;
		bit neg;
		neg = total < 0;
		mag = (neg ? -total : total) * 180;
		g = (drift_div == 0) ? 1 : drift_div;
		ip = mag / g;
		if (ip >= (64'd1 << (31 - FB)))
			h = 64'd1 << 31;
		else
			h = (ip << FB) + ((mag % g) << FB) / g;
		if (neg)
			return h > (64'd1 << 31) ? -64'sd2147483648 : -longint'(h);
		return h > 64'd2147483647 ? 64'sd2147483647 : longint'(h);
	endfunction

	function automatic longint add_sat(input longint acc, input longint d);
		if (d > 0 && acc > POS_HI - d)
			return POS_HI;
		if (d < 0 && acc < POS_LO - d)
			return POS_LO;
		return acc + d;
	endfunction

	function automatic pose_t advance_pose(input longint side, input longint fwd,
			input longint ga, input longint gb);
		longint head, rad, ds, df, dth, lx, ly, s, c, chord, ratio, gx, gy;
		pose_t p;
		head = scale_heading(ga + gb);
		rad = head * PI_FIX / (64'sd180 * Q30);
		ds = side - prev_side;
		df = fwd - prev_fwd;
		dth = rad - prev_rad;
		if (dth != 0) begin
			rotate_unit(dth, FB + 1, s, c);
			chord = 2 * s;
			ratio = clip(chord * (64'sd1 << FB) / dth, -Q30, Q30);
			lx = ((ds * ratio) >>> (30 - FB)) + ((chord * side_off) >>> 30);
			ly = ((df * ratio) >>> (30 - FB)) + ((chord * fwd_off) >>> 30);
		end else begin
			lx = ds * (64'sd1 << FB);
			ly = df * (64'sd1 << FB);
		end
		rotate_unit(prev_rad, FB, s, c);
		gx = mul_frac(lx, c) + mul_frac(ly, s);
		gy = mul_frac(ly, c) - mul_frac(lx, s);
		sum_x = add_sat(sum_x, gx);
		sum_y = add_sat(sum_y, gy);
		prev_side = side;
		prev_fwd = fwd;
		prev_rad = rad;
		p.x = sum_x[47:0];
		p.y = sum_y[47:0];
		p.h = head[31:0];
		return p;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pose_t e;
		if (!arst_n) begin
			pose_q.delete();
			drift_div <= GYRO_SCALE_RST;
			side_off <= 0;
			fwd_off <= 0;
			prev_side = 0;
			prev_fwd = 0;
			prev_rad = 0;
			sum_x = 0;
			sum_y = 0;
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (aot_reg_t'(cfg_index))
					REG_GYRO_SCALE:  drift_div <= cfg_data[30:0];
					REG_SIDE_OFFSET: side_off <= longint'(signed'(cfg_data));
					REG_FWD_OFFSET:  fwd_off <= longint'(signed'(cfg_data));
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				pose_q.push_back(advance_pose(side_count, forward_count,
					gyro_a_angle, gyro_b_angle));
			if (out_valid && out_ready) begin
				if (pose_q.size() == 0) begin
					if (errors < 10)
						$display("unexpected result x=%h y=%h h=%h", pos_x, pos_y,
							heading_angle);
					errors <= errors + 1;
				end else begin
					e = pose_q.pop_front();
					if (e.x !== pos_x || e.y !== pos_y || e.h !== heading_angle) begin
						if (errors < 10)
							$display("mismatch exp x=%h y=%h h=%h got x=%h y=%h h=%h",
								e.x, e.y, e.h, pos_x, pos_y, heading_angle);
						errors <= errors + 1;
					end
				end
			end
			pending <= pose_q.size();
		end
	end
endmodule

// File: dv/arc_odometry_tracker_core_tb.sv
// Stimulus top for the arc odometry tracker: clock, reset, register writes,
// directed and random items with random gaps on both sides, and the verdict.
// Depends on aot_pkg, arc_odometry_tracker_core and arc_odometry_tracker_checker.
module arc_odometry_tracker_core_tb import aot_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk, arst_n;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [31:0] side_count, forward_count, gyro_a_angle, gyro_b_angle;
	logic out_valid, out_ready;
	logic signed [47:0] pos_x, pos_y;
	logic signed [31:0] heading_angle;
	int errors, pending;
	logic in_taken, cfg_taken;
	bit quiet, long_hold;
	int run_side, run_fwd, run_ga, run_gb;

	arc_odometry_tracker_core dut (.*);

	arc_odometry_tracker_checker checker_i (
		.clk, .arst_n, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.in_valid, .in_ready, .side_count, .forward_count, .gyro_a_angle,
		.gyro_b_angle, .out_valid, .out_ready, .pos_x, .pos_y, .heading_angle,
		.errors, .pending
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		in_taken <= in_valid && in_ready;
		cfg_taken <= cfg_valid && cfg_ready;
	end

	initial begin
		#50ms;
		$display("Some tests failed");
		$finish;
	end

	// receiver: short stalls mostly, a few long ones, one long hold on request
	initial begin
		int r;
		out_ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_ready = 0;
				repeat (3000) @(negedge clk);
				long_hold = 0;
			end else if (quiet) begin
				out_ready = 1;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					out_ready = 1;
				end else if (r < 95) begin
					out_ready = 0;
					repeat ($urandom_range(1, 4)) @(negedge clk);
					out_ready = 1;
				end else begin
					out_ready = 0;
					repeat ($urandom_range(20, 80)) @(negedge clk);
					out_ready = 1;
				end
			end
		end
	end

	task automatic put_item(input int s, input int f, input int a, input int b);
		int gap;
		side_count = s;
		forward_count = f;
		gyro_a_angle = a;
		gyro_b_angle = b;
		in_valid = 1;
		do @(negedge clk); while (!in_taken);
		gap = quiet ? 0 : ($urandom_range(0, 9) < 7 ? $urandom_range(0, 3)
			: $urandom_range(10, 60));
		if (gap > 0) begin
			in_valid = 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic put_reg(input aot_reg_t idx, input logic [31:0] d);
		cfg_index = idx;
		cfg_data = d;
		cfg_valid = 1;
		do @(negedge clk); while (!cfg_taken);
		cfg_valid = 0;
	endtask

	task automatic drain;
		in_valid = 0;
		do @(negedge clk); while (pending != 0);
	endtask

	task automatic random_item;
		int r;
		r = $urandom_range(0, 99);
		if (r < 15) begin
			put_item($urandom, $urandom, $urandom, $urandom);
		end else begin
			run_side += $urandom_range(0, 4000) - 2000;
			run_fwd += $urandom_range(0, 4000) - 2000;
			if (r > 30) begin
				run_ga += $urandom_range(0, 40 << 16) - (20 << 16);
				run_gb += $urandom_range(0, 40 << 16) - (20 << 16);
			end
			put_item(run_side, run_fwd, run_ga, run_gb);
		end
	endtask

	initial begin
		in_valid = 0;
		cfg_valid = 0;
		cfg_index = REG_GYRO_SCALE;
		cfg_data = 0;
		side_count = 0;
		forward_count = 0;
		gyro_a_angle = 0;
		gyro_b_angle = 0;
		quiet = 0;
		long_hold = 0;
		run_side = 0;
		run_fwd = 0;
		run_ga = 0;
		run_gb = 0;
		arst_n = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		put_item(0, 0, 0, 0);
		put_item(100, 200, 0, 0);
		put_item(1000, -500, 90 << 16, 90 << 16);
		put_item(1000, -500, 90 << 16, 90 << 16);
		put_item(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
		put_item(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
		put_item(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
		put_item(-1, -1, -1, -1);
		put_item(32'h7FFFFFFF, 32'h7FFFFFFF, 45 << 16, -(30 << 16));
		put_item(32'h80000000, 32'h80000000, -(180 << 16), 180 << 16);
		put_item(32'h7FFFFFFF, 32'h7FFFFFFF, 1, 0);
		put_item(32'h80000000, 32'h80000000, 1, 0);
		put_item(0, 0, 720 << 16, -(10 << 16));
		drain();

		put_reg(REG_UNUSED, 32'hFFFFFFFF);
		put_reg(REG_GYRO_SCALE, 32'h80000000);
		put_reg(REG_SIDE_OFFSET, 32'h80000000);
		put_reg(REG_FWD_OFFSET, 32'h7FFFFFFF);
		put_item(5, 5, 3, 4);
		put_item(10, -10, -3, 0);
		repeat (40) random_item();
		drain();

		put_reg(REG_GYRO_SCALE, 32'h7FFFFFFF);
		put_reg(REG_SIDE_OFFSET, 32'h7FFFFFFF);
		put_reg(REG_FWD_OFFSET, 32'h80000000);
		put_item(1, 1, 32'h7FFFFFFF, 32'h7FFFFFFF);
		repeat (40) random_item();
		drain();

		put_reg(REG_GYRO_SCALE, 1);
		put_reg(REG_SIDE_OFFSET, 0);
		repeat (30) random_item();
		drain();

		put_reg(REG_GYRO_SCALE, 360 << 16);
		put_reg(REG_SIDE_OFFSET, $urandom_range(0, 20 << 16) - (10 << 16));
		put_reg(REG_FWD_OFFSET, $urandom_range(0, 20 << 16) - (10 << 16));
		repeat (150) random_item();
		long_hold = 1;
		repeat (20) random_item();
		quiet = 1;
		repeat (100) random_item();
		quiet = 0;
		drain();

		put_reg(REG_GYRO_SCALE, $urandom_range(1 << 16, 1000 << 16));
		put_reg(REG_SIDE_OFFSET, $urandom);
		put_reg(REG_FWD_OFFSET, $urandom);
		repeat (350) random_item();
		drain();

		repeat (400) @(negedge clk);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule

// File: filelist.f
sv/aot_pkg.sv
sv/aot_div.sv
sv/aot_cordic.sv
sv/aot_mul.sv
sv/arc_odometry_tracker_core.sv
dv/arc_odometry_tracker_checker.sv
dv/arc_odometry_tracker_core_tb.sv
